/* rtl/core/heightmap_normal_map_encoder_defines.svh */
// Assertion macros shared by the height map normal encoder RTL.
`ifndef HEIGHTMAP_NORMAL_MAP_ENCODER_DEFINES_SVH
`define HEIGHTMAP_NORMAL_MAP_ENCODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define HNME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define HNME_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/hnme_pkg.sv */
// Types, constants and arithmetic helpers of the height map normal encoder.
package hnme_pkg;

  // Input word.
  typedef struct packed {
    logic       op;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [15:0] height_sample;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [7:0] out_x;
    logic [7:0] out_y;
    logic [7:0] normal_x_byte;
    logic [7:0] normal_y_byte;
    logic [7:0] normal_z_byte;
    logic [7:0] alpha_byte;
  } out_word_t;

  // Control into and status out of the root/divide unit.
  typedef struct packed {
    logic start;
    logic mode;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic MODE_SQRT = 1'b0;
  localparam logic MODE_DIV  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WRAP   = 3'd2;
  localparam logic [2:0] REG_GAIN_X = 3'd3;
  localparam logic [2:0] REG_GAIN_Y = 3'd4;

  localparam int CFG_DATA_W = 24;
  localparam int MUL_W      = 29;
  localparam int PROD_W     = 58;
  localparam int RND_W      = 42;
  localparam int ACC_W      = 20;
  localparam int GRAD_W     = 28;
  localparam int MAG_W      = 17;
  localparam int NRM_W      = 18;
  localparam int Q_W        = 37;

  localparam logic signed [MUL_W-1:0] EDGE_WEIGHT = 29'sd92681;
  localparam logic signed [MUL_W-1:0] UNIT_WEIGHT = 29'sd65536;
  localparam logic [MAG_W-1:0]        MAG_MAX     = 17'd65536;

  // Neighbour selection along one axis.
  localparam logic [1:0] SEL_PREV = 2'd0;
  localparam logic [1:0] SEL_MID  = 2'd1;
  localparam logic [1:0] SEL_NEXT = 2'd2;

  // Read step k: step 0 is the centre, steps 1..8 walk the neighbours
  // row by row: previous row, own row (left, right), next row.
  function automatic logic [1:0] nb_col(input logic [3:0] k);
    logic [1:0] s;
    case (k)
      4'd1, 4'd4, 4'd6: s = SEL_PREV;
      4'd3, 4'd5, 4'd8: s = SEL_NEXT;
      default:          s = SEL_MID;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] nb_row(input logic [3:0] k);
    logic [1:0] s;
    case (k)
      4'd1, 4'd2, 4'd3: s = SEL_PREV;
      4'd6, 4'd7, 4'd8: s = SEL_NEXT;
      default:          s = SEL_MID;
    endcase
    return s;
  endfunction

  // Neighbour n (0..7): edge neighbours are weighted by sqrt(2).
  function automatic logic nb_edge(input logic [2:0] n);
    return (n == 3'd1) || (n == 3'd3) || (n == 3'd4) || (n == 3'd6);
  endfunction

  // Contribution of neighbour n to right-left (+1, -1 or none).
  function automatic logic [1:0] nb_dx(input logic [2:0] n);
    logic [1:0] s;
    case (n)
      3'd0, 3'd3, 3'd5: s = 2'b11;
      3'd2, 3'd4, 3'd7: s = 2'b01;
      default:          s = 2'b00;
    endcase
    return s;
  endfunction

  // Contribution of neighbour n to next row minus previous row (+1, -1 or none).
  function automatic logic [1:0] nb_dy(input logic [2:0] n);
    logic [1:0] s;
    case (n)
      3'd0, 3'd1, 3'd2: s = 2'b11;
      3'd5, 3'd6, 3'd7: s = 2'b01;
      default:          s = 2'b00;
    endcase
    return s;
  endfunction

  // Drop 16 fraction bits, rounding to nearest with ties away from zero.
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] r;
    logic signed [RND_W-1:0] q;
    m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    r = (m + PROD_W'(32768)) >> 16;
    q = RND_W'(r);
    return v[PROD_W-1] ? -q : q;
  endfunction

  // Saturate to Q12.16.
  function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    logic signed [GRAD_W-1:0] r;
    hi = RND_W'(134217727);
    lo = -RND_W'(134217728);
    if (v > hi) begin
      r = GRAD_W'(hi);
    end else if (v < lo) begin
      r = GRAD_W'(lo);
    end else begin
      r = GRAD_W'(v);
    end
    return r;
  endfunction

  // Clamp a normal component to [-1, 1] in Q.16.
  function automatic logic signed [NRM_W-1:0] clamp_unit(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] hi;
    logic signed [NRM_W-1:0] r;
    hi = RND_W'(65536);
    if (v > hi) begin
      r = NRM_W'(hi);
    end else if (v < -hi) begin
      r = NRM_W'(-hi);
    end else begin
      r = NRM_W'(v);
    end
    return r;
  endfunction

  // Encode a component in [-1, 1] as round((v+1)*127.5).
  function automatic logic [7:0] enc_byte(input logic signed [NRM_W-1:0] v);
    logic signed [NRM_W:0] u;
    logic [26:0] t;
    logic [9:0] b;
    u = {v[NRM_W-1], v} + (NRM_W+1)'(65536);
    t = 27'(u[NRM_W-1:0]) * 27'd255 + 27'd65536;
    b = t[26:17];
    return (b > 10'd255) ? 8'd255 : b[7:0];
  endfunction

  // Height to byte, round(h*255).
  function automatic logic [7:0] alpha_enc(input logic [15:0] h);
    logic [23:0] t;
    t = 24'(h) * 24'd255 + 24'd32768;
    return t[23:16];
  endfunction

endpackage

/* rtl/core/heightmap_normal_map_encoder.sv */
// Top level of the height map normal encoder: sequencer, datapath, registers.
//
// A write word stores one height sample. A compute word streams the centre
// and its eight neighbours out of the single-port height RAM through one
// shared multiplier, forms the gradients and their squares, runs the shared
// root/divide unit for the square root and then for the reciprocal, and
// finally scales and encodes the normal. A compute at a pixel outside the
// image gives no result. The input is not ready while a compute is in
// flight or its result waits to be loaded into the output register. Height
// RAM entries read before being written return whatever the RAM holds.
`include "heightmap_normal_map_encoder_defines.svh"
module heightmap_normal_map_encoder
  import hnme_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_GX   = 4'd2;
  localparam logic [3:0] ST_GY   = 4'd3;
  localparam logic [3:0] ST_SQX  = 4'd4;
  localparam logic [3:0] ST_SQY  = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_NX   = 4'd9;
  localparam logic [3:0] ST_NY   = 4'd10;
  localparam logic [3:0] ST_NYW  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  // Configuration registers.
  logic [8:0]  image_width;
  logic [8:0]  image_height;
  logic        wrap_edges;
  logic [23:0] gain_x;
  logic [23:0] gain_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
      wrap_edges   <= 1'b0;
      gain_x       <= 24'd65536;
      gain_y       <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_wdata[8:0];
        REG_HEIGHT: image_height <= cfg_wdata[8:0];
        REG_WRAP:   wrap_edges   <= cfg_wdata[0];
        REG_GAIN_X: gain_x       <= cfg_wdata;
        REG_GAIN_Y: gain_y       <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Effective image size.
  logic [8:0] eff_w;
  logic [8:0] eff_h;

  always_comb begin
    if (image_width == '0) begin
      eff_w = 9'd1;
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = 9'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = 9'd1;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = 9'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  // Control and datapath registers.
  logic [3:0]                state;
  logic [3:0]                k;
  logic [8:0]                px;
  logic [8:0]                py;
  logic [8:0]                px0;
  logic [8:0]                px2;
  logic [8:0]                py0;
  logic [8:0]                py2;
  logic [15:0]               c;
  logic signed [ACC_W-1:0]   dx;
  logic signed [ACC_W-1:0]   dy;
  logic signed [GRAD_W-1:0]  gx;
  logic signed [GRAD_W-1:0]  gy;
  logic [PROD_W-1:0]         sq;
  logic [MAG_W-1:0]          mag;
  logic signed [NRM_W-1:0]   nx;
  logic signed [NRM_W-1:0]   ny;
  logic signed [PROD_W-1:0]  mul_p;

  logic                      accept;
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [15:0]               ram_rdata;
  logic [8:0]                rd_x;
  logic [8:0]                rd_y;
  logic [31:0]               addr_full;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [16:0]        diff_c;
  logic signed [RND_W-1:0]   term_full;
  logic signed [ACC_W-1:0]   term;
  logic [2:0]                acc_n;
  logic [2:0]                mul_n;
  logic [1:0]                sdx;
  logic [1:0]                sdy;
  logic [PROD_W-1:0]         s_sum;
  logic [63:0]               iter_opnd;
  iter_ctl_t                 iter_ctl;
  iter_sts_t                 iter_sts;
  logic [Q_W-1:0]            iter_q;
  logic                      out_load;
  logic                      in_range;
  logic [8:0]                ix;
  logic [8:0]                iy;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ix       = {1'b0, in_data.pixel_x};
  assign iy       = {1'b0, in_data.pixel_y};
  assign in_range = (ix < eff_w) && (iy < eff_h);
  assign ram_we   = accept && (in_data.op == OP_WRITE) &&
                    (32'(in_data.pixel_x) < MAX_WIDTH) &&
                    (32'(in_data.pixel_y) < MAX_HEIGHT);

  // Pick the coordinate of read step k, or the input pixel while idle.
  always_comb begin
    case (nb_col(k))
      SEL_PREV: rd_x = px0;
      SEL_NEXT: rd_x = px2;
      default:  rd_x = px;
    endcase
    case (nb_row(k))
      SEL_PREV: rd_y = py0;
      SEL_NEXT: rd_y = py2;
      default:  rd_y = py;
    endcase
    if (state == ST_IDLE) begin
      addr_full = (32'(in_data.pixel_y) << XW) | 32'(in_data.pixel_x);
    end else begin
      addr_full = (32'(rd_y) << XW) | 32'(rd_x);
    end
    ram_addr = addr_full[AW-1:0];
  end

  hnme_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_height_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.height_sample),
    .rdata (ram_rdata)
  );

  // Neighbour indexes: multiply step k-2, accumulate step k-3.
  assign mul_n     = 3'(k - 4'd2);
  assign acc_n     = 3'(k - 4'd3);
  assign diff_c    = 17'($signed({1'b0, c})) - 17'($signed({1'b0, ram_rdata}));
  assign term_full = rnd16(mul_p);
  assign term      = term_full[ACC_W-1:0];
  assign sdx       = nb_dx(acc_n);
  assign sdy       = nb_dy(acc_n);
  assign s_sum     = PROD_W'(64'd1 << 32) + sq + PROD_W'(mul_p);
  assign iter_opnd = (state == ST_SUM) ? {s_sum[55:0], 8'b0}
                                       : 64'(37'(64'd1 << 36) + 37'(iter_q[31:1]));

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_READ: begin
        if (k >= 4'd2 && k <= 4'd9) begin
          mul_a = MUL_W'(diff_c);
          mul_b = nb_edge(mul_n) ? EDGE_WEIGHT : UNIT_WEIGHT;
        end
      end
      ST_GX: begin
        mul_a = MUL_W'($signed({1'b0, gain_x}));
        mul_b = MUL_W'(dx);
      end
      ST_GY: begin
        mul_a = MUL_W'($signed({1'b0, gain_y}));
        mul_b = MUL_W'(dy);
      end
      ST_SQX: begin
        mul_a = MUL_W'(gx);
        mul_b = MUL_W'(gx);
      end
      ST_SQY: begin
        mul_a = MUL_W'(gy);
        mul_b = MUL_W'(gy);
      end
      ST_NX: begin
        mul_a = MUL_W'(gx);
        mul_b = MUL_W'($signed({1'b0, mag}));
      end
      ST_NY: begin
        mul_a = MUL_W'(gy);
        mul_b = MUL_W'($signed({1'b0, mag}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Start the root, then the reciprocal.
  always_comb begin
    iter_ctl.start = 1'b0;
    iter_ctl.mode  = MODE_SQRT;
    if (state == ST_SUM) begin
      iter_ctl.start = 1'b1;
    end else if (state == ST_SQRT && iter_sts.done) begin
      iter_ctl.start = 1'b1;
      iter_ctl.mode  = MODE_DIV;
    end
  end

  hnme_rootdiv u_rootdiv (
    .clk     (clk),
    .rst     (rst),
    .ctl     (iter_ctl),
    .opnd    (iter_opnd),
    .divisor (iter_q[31:0]),
    .sts     (iter_sts),
    .result  (iter_q)
  );

  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && in_data.op == OP_COMPUTE && in_range) begin
            state <= ST_READ;
            k     <= '0;
          end
        end
        ST_READ: begin
          k <= k + 4'd1;
          if (k == 4'd10) begin
            state <= ST_GX;
          end
        end
        ST_GX:   state <= ST_GY;
        ST_GY:   state <= ST_SQX;
        ST_SQX:  state <= ST_SQY;
        ST_SQY:  state <= ST_SUM;
        ST_SUM:  state <= ST_SQRT;
        ST_SQRT: begin
          if (iter_sts.done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (iter_sts.done) begin
            state <= ST_NX;
          end
        end
        ST_NX:   state <= ST_NY;
        ST_NY:   state <= ST_NYW;
        ST_NYW:  state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      px  <= ix;
      py  <= iy;
      px0 <= (ix == '0) ? (wrap_edges ? eff_w - 9'd1 : '0) : ix - 9'd1;
      px2 <= (ix + 9'd1 >= eff_w) ? (wrap_edges ? '0 : eff_w - 9'd1) : ix + 9'd1;
      py0 <= (iy == '0) ? (wrap_edges ? eff_h - 9'd1 : '0) : iy - 9'd1;
      py2 <= (iy + 9'd1 >= eff_h) ? (wrap_edges ? '0 : eff_h - 9'd1) : iy + 9'd1;
      dx  <= '0;
      dy  <= '0;
    end
    if (state == ST_READ) begin
      if (k == 4'd1) begin
        c <= ram_rdata;
      end
      if (k >= 4'd3) begin
        if (sdx == 2'b01) begin
          dx <= dx + term;
        end else if (sdx == 2'b11) begin
          dx <= dx - term;
        end
        if (sdy == 2'b01) begin
          dy <= dy + term;
        end else if (sdy == 2'b11) begin
          dy <= dy - term;
        end
      end
    end
    if (state == ST_GY) begin
      gx <= sat_grad(term_full);
    end
    if (state == ST_SQX) begin
      gy <= sat_grad(term_full);
    end
    if (state == ST_SQY) begin
      sq <= mul_p;
    end
    if (state == ST_DIV && iter_sts.done) begin
      mag <= (iter_q > Q_W'(MAG_MAX)) ? MAG_MAX : iter_q[MAG_W-1:0];
    end
    if (state == ST_NY) begin
      nx <= clamp_unit(term_full);
    end
    if (state == ST_NYW) begin
      ny <= clamp_unit(term_full);
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_x         <= px[7:0];
      out_data.out_y         <= py[7:0];
      out_data.normal_x_byte <= enc_byte(nx);
      out_data.normal_y_byte <= enc_byte(ny);
      out_data.normal_z_byte <= enc_byte($signed({1'b0, mag}));
      out_data.alpha_byte    <= alpha_enc(c);
    end
  end

  `HNME_ASSERT(a_busy_blocks_input, iter_sts.busy |-> !in_ready, "input ready while unit busy")
  `HNME_ASSERT(a_done_in_wait, iter_sts.done |-> (state == ST_SQRT || state == ST_DIV), "unit done outside a wait state")
  `HNME_ASSERT(a_write_only_idle, ram_we |-> (state == ST_IDLE), "height RAM written during a compute")
  `HNME_ASSERT(a_mag_bounded, (state == ST_NX) |-> (mag <= MAG_MAX), "magnitude above one")
  `HNME_ASSERT_ALWAYS(a_reset_idle, (!rst && $past(rst)) |-> (state == ST_IDLE && !out_valid), "not idle after reset")

endmodule

/* rtl/core/hnme_ram.sv */
// Generic single-port RAM with registered read.
module hnme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read one entry per cycle, writing it too when we is set; a write reads the old value.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/hnme_rootdiv.sv */
// Shared iterative unit: bit-serial square root and restoring division.
module hnme_rootdiv
  import hnme_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  iter_ctl_t     ctl,
  input  logic [63:0]   opnd,
  input  logic [31:0]   divisor,
  output iter_sts_t     sts,
  output logic [Q_W-1:0] result
);

  localparam int REM_W = 36;
  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd37;

  logic [63:0]      src;
  logic [REM_W-1:0] rem;
  logic [Q_W-1:0]   q;
  logic [31:0]      dvs;
  logic [5:0]       cnt;
  logic             mode;
  logic             busy;
  logic             done;
  logic [REM_W-1:0] op_a;
  logic [REM_W-1:0] op_b;
  logic [REM_W:0]   diff;
  logic             ge;

  // One compare-subtract per step, shared by both operations.
  always_comb begin
    if (mode == MODE_SQRT) begin
      op_a = {rem[REM_W-3:0], src[63:62]};
      op_b = {q[REM_W-3:0], 2'b01};
    end else begin
      op_a = {rem[REM_W-2:0], src[63]};
      op_b = REM_W'(dvs);
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[REM_W];
  end

  // Sequence the steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      mode <= MODE_SQRT;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        mode <= ctl.mode;
        cnt  <= (ctl.mode == MODE_SQRT) ? SQRT_STEPS - 6'd1 : DIV_STEPS - 6'd1;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift operand in, remainder and quotient along; hold the divisor.
  always_ff @(posedge clk) begin
    if (ctl.start && !busy) begin
      src <= (ctl.mode == MODE_SQRT) ? opnd : {opnd[Q_W-1:0], 27'b0};
      rem <= '0;
      q   <= '0;
      dvs <= divisor;
    end else if (busy) begin
      src <= (mode == MODE_SQRT) ? {src[61:0], 2'b00} : {src[62:0], 1'b0};
      rem <= ge ? diff[REM_W-1:0] : op_a;
      q   <= {q[Q_W-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign result   = q;

endmodule
